/* design/packet_reassembler_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the packet reassembler
// Both macros sample on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PACKET_REASSEMBLER_CORE_ASSERT_SVH
`define PACKET_REASSEMBLER_CORE_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define PRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check the consequent in the cycle after the antecedent
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/prc_pkg.sv */
// ---------------------------------------------------------------------------
// prc_pkg
// Shared constants, codes and the front-to-back command type of the
// packet reassembler.
// ---------------------------------------------------------------------------
package prc_pkg;

	localparam int PACKET_BYTES_DEF  = 20;
	localparam int MESSAGE_BYTES_DEF = 256;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// id byte plus flag/sequence byte
	localparam int HDR_BYTES  = 2;
	localparam int BEAT_BYTES = 8;

	// command widths cover the largest supported store (4096 bytes plus lone area)
	localparam int CMD_ADDR_W = 13;
	localparam int CMD_LEN_W  = 13;

	localparam int         MORE_BIT = 7;
	localparam logic [7:0] SEQ_MASK = 8'h7f;

	typedef enum logic [2:0] {
		ACT_DROP,
		ACT_APPEND,
		ACT_FINISH,
		ACT_RESTART,
		ACT_LONE
	} prc_act_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_BEAT
	} prc_bk_state_t;

	typedef struct packed {
		logic                  wr;
		logic                  emit;
		logic                  lone;
		logic [CMD_ADDR_W-1:0] addr;
		logic [7:0]            data;
		logic [CMD_LEN_W-1:0]  len;
	} prc_cmd_t;

endpackage

/* design/prc_front.sv */
// ---------------------------------------------------------------------------
// prc_front
// Frames the byte stream into packets, classifies each packet on its header
// and issues byte-write and emit commands for the back end.
// ---------------------------------------------------------------------------
module prc_front import prc_pkg::*; #(
	parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_accept,
	input  logic [7:0] rx_byte,
	output logic       cmd_push,
	output prc_cmd_t   cmd
);

	localparam int PAYLOAD_BYTES = PACKET_BYTES - HDR_BYTES;
	localparam int POS_W         = $clog2(PACKET_BYTES);
	localparam int FILL_W        = $clog2(MESSAGE_BYTES + 1);
	localparam int SUM_W         = $clog2(MESSAGE_BYTES + PAYLOAD_BYTES + 1);
	localparam int MSG_WORDS     = (MESSAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int LONE_WORDS    = (PAYLOAD_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int ADDR_W        = $clog2((MSG_WORDS + LONE_WORDS) * BEAT_BYTES);

	localparam logic [POS_W-1:0]  POS_ID    = '0;
	localparam logic [POS_W-1:0]  POS_HDR   = POS_W'(1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(PACKET_BYTES - 1);
	localparam logic [SUM_W-1:0]  PAY_SUM   = SUM_W'(PAYLOAD_BYTES);
	localparam logic [SUM_W-1:0]  MSG_SUM   = SUM_W'(MESSAGE_BYTES);
	localparam logic [FILL_W-1:0] PAY_FILL  = FILL_W'(PAYLOAD_BYTES);
	localparam logic [ADDR_W-1:0] LONE_ADDR = ADDR_W'(MSG_WORDS * BEAT_BYTES);

	logic [POS_W-1:0]  pos_q;
	logic [7:0]        id_q;
	prc_act_t          act_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [FILL_W-1:0] emit_len_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        exp_id_q;
	logic [7:0]        exp_seq_q;
	logic              exp_more_q;

	logic [SUM_W-1:0]  fill_sum;
	logic              overflow;
	logic [7:0]        hdr_seq;
	logic              hdr_more;
	logic              out_of_order;

	prc_act_t          act_d;
	logic [ADDR_W-1:0] base_d;
	logic [FILL_W-1:0] len_d;
	logic [FILL_W-1:0] fill_d;
	logic [7:0]        exp_id_d;
	logic [7:0]        exp_seq_d;
	logic              exp_more_d;

	logic              act_writes;
	logic              act_emits;

	assign fill_sum     = SUM_W'(fill_q) + PAY_SUM;
	assign overflow     = fill_sum > MSG_SUM;
	assign hdr_seq      = rx_byte & SEQ_MASK;
	assign hdr_more     = rx_byte[MORE_BIT];
	assign out_of_order = (exp_seq_q != hdr_seq) || (exp_more_q && (exp_id_q != id_q));

	// decide the fate of the packet from its header and the running state
	always_comb begin
		act_d      = ACT_DROP;
		base_d     = '0;
		len_d      = '0;
		fill_d     = fill_q;
		exp_id_d   = exp_id_q;
		exp_seq_d  = exp_seq_q;
		exp_more_d = exp_more_q;
		if (overflow) begin
			fill_d     = '0;
			exp_seq_d  = '0;
			exp_more_d = 1'b0;
		end else if (out_of_order) begin
			if (hdr_seq == '0) begin
				if (hdr_more) begin
					act_d      = ACT_RESTART;
					fill_d     = PAY_FILL;
					exp_id_d   = id_q;
					exp_seq_d  = 8'd1;
					exp_more_d = 1'b1;
				end else begin
					act_d  = ACT_LONE;
					base_d = LONE_ADDR;
					len_d  = PAY_FILL;
				end
			end
		end else begin
			base_d = ADDR_W'(fill_q);
			if (hdr_more) begin
				act_d      = ACT_APPEND;
				fill_d     = FILL_W'(fill_sum);
				exp_id_d   = id_q;
				exp_seq_d  = hdr_seq + 8'd1;
				exp_more_d = 1'b1;
			end else begin
				act_d      = ACT_FINISH;
				len_d      = FILL_W'(fill_sum);
				fill_d     = '0;
				exp_seq_d  = '0;
				exp_more_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			act_q      <= ACT_DROP;
			fill_q     <= '0;
			exp_id_q   <= '0;
			exp_seq_q  <= '0;
			exp_more_q <= 1'b0;
		end else if (rx_accept) begin
			pos_q <= (pos_q == POS_LAST) ? POS_ID : pos_q + POS_W'(1);
			if (pos_q == POS_HDR) begin
				act_q      <= act_d;
				fill_q     <= fill_d;
				exp_id_q   <= exp_id_d;
				exp_seq_q  <= exp_seq_d;
				exp_more_q <= exp_more_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_accept) begin
			if (pos_q == POS_ID) begin
				id_q <= rx_byte;
			end
			if (pos_q == POS_HDR) begin
				wr_addr_q  <= base_d;
				emit_len_q <= len_d;
			end else if (pos_q > POS_HDR) begin
				wr_addr_q <= wr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_comb begin
		unique case (act_q) inside
			ACT_FINISH, ACT_LONE: begin
				act_writes = 1'b1;
				act_emits  = 1'b1;
			end
			ACT_APPEND, ACT_RESTART: begin
				act_writes = 1'b1;
				act_emits  = 1'b0;
			end
			default: begin
				act_writes = 1'b0;
				act_emits  = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd.wr   = rx_accept && (pos_q > POS_HDR) && act_writes;
		cmd.emit = rx_accept && (pos_q == POS_LAST) && act_emits;
		cmd.lone = act_q == ACT_LONE;
		cmd.addr = CMD_ADDR_W'(wr_addr_q);
		cmd.data = rx_byte;
		cmd.len  = CMD_LEN_W'(emit_len_q);
		cmd_push = cmd.wr || cmd.emit;
	end

endmodule

/* design/prc_queue.sv */
// ---------------------------------------------------------------------------
// prc_queue
// Short command queue between front and back end.
// ---------------------------------------------------------------------------
module prc_queue import prc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  prc_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output prc_cmd_t head_cmd,
	output logic     empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	prc_cmd_t          slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = count_q == CNT_FULL;
	assign empty    = count_q == '0;
	assign head_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/prc_back.sv */
// ---------------------------------------------------------------------------
// prc_back
// Holds the message memory, carries out byte writes and drains finished
// messages as 64-bit beats.
// ---------------------------------------------------------------------------
module prc_back import prc_pkg::*; #(
	parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  prc_cmd_t    cmd,
	output logic        cmd_pop,
	output logic        beat_valid,
	input  logic        beat_stall,
	output logic [63:0] data_word,
	output logic [3:0]  valid_bytes,
	output logic [8:0]  message_length,
	output logic        last_beat
);

	localparam int PAYLOAD_BYTES = PACKET_BYTES - HDR_BYTES;
	localparam int MSG_WORDS     = (MESSAGE_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int LONE_WORDS    = (PAYLOAD_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int MEM_WORDS     = MSG_WORDS + LONE_WORDS;
	localparam int LANE_W        = $clog2(BEAT_BYTES);
	localparam int ADDR_W        = $clog2(MEM_WORDS * BEAT_BYTES);
	localparam int WORD_W        = ADDR_W - LANE_W;
	localparam int LEN_W         = $clog2(MESSAGE_BYTES + 1);

	localparam logic [WORD_W-1:0] LONE_WORD = WORD_W'(MSG_WORDS);
	localparam logic [LEN_W-1:0]  BEAT_REM  = LEN_W'(BEAT_BYTES);

	logic [BEAT_BYTES*8-1:0] msg_mem_q [MEM_WORDS];
	logic [BEAT_BYTES*8-1:0] rdata_q;

	prc_bk_state_t      state_q;
	prc_bk_state_t      state_d;
	logic [WORD_W-1:0]  rd_word_q;
	logic [LEN_W-1:0]   remain_q;
	logic               last_q;
	logic [3:0]         vbytes_q;
	logic [8:0]         len_q;

	logic               rd_en;
	logic               advance;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [WORD_W-1:0]  wr_word;
	logic [LANE_W-1:0]  wr_lane;

	assign wr_en   = cmd_pop && cmd.wr;
	assign wr_addr = cmd.addr[ADDR_W-1:0];
	assign wr_word = wr_addr[ADDR_W-1:LANE_W];
	assign wr_lane = wr_addr[LANE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		rd_en      = 1'b0;
		advance    = 1'b0;
		beat_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.emit) begin
						state_d = BK_READ;
					end
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_BEAT;
			end
			BK_BEAT: begin
				beat_valid = 1'b1;
				if (!beat_stall) begin
					if (last_q) begin
						state_d = BK_IDLE;
					end else begin
						advance = 1'b1;
						state_d = BK_READ;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// at most one byte lane written and one whole word read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			msg_mem_q[wr_word][{wr_lane, 3'b000} +: 8] <= cmd.data;
		end
		if (rd_en) begin
			rdata_q <= msg_mem_q[rd_word_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_word_q <= '0;
			remain_q  <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cmd_pop && cmd.emit) begin
				rd_word_q <= cmd.lone ? LONE_WORD : '0;
				remain_q  <= cmd.len[LEN_W-1:0];
			end else if (advance) begin
				rd_word_q <= rd_word_q + WORD_W'(1);
				remain_q  <= remain_q - BEAT_REM;
			end
			if (rd_en) begin
				last_q <= remain_q <= BEAT_REM;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.emit) begin
			len_q <= cmd.len[8:0];
		end
		if (rd_en) begin
			vbytes_q <= (remain_q > BEAT_REM) ? 4'(BEAT_BYTES) : remain_q[3:0];
		end
	end

	// zero the lanes beyond the valid count
	always_comb begin
		for (int k = 0; k < BEAT_BYTES; k++) begin
			data_word[8*k +: 8] = (4'(k) < vbytes_q) ? rdata_q[8*k +: 8] : 8'h00;
		end
	end

	assign valid_bytes    = vbytes_q;
	assign message_length = len_q;
	assign last_beat      = last_q;

endmodule

/* design/packet_reassembler_core.sv */
// ---------------------------------------------------------------------------
// packet_reassembler_core
// Frames a byte stream into packets, reassembles in-order packets into a
// message store and drains each completed message as 64-bit beats.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  rx      | rx_valid / rx_stall    | rx_byte
//  beat    | beat_valid / beat_stall| data_word, valid_bytes, message_length,
//          |                        | last_beat
//
// The front takes one byte per cycle while rx_stall is low and turns each payload byte of a
// kept packet into a write command; the back retires one command per cycle into the message
// memory while idle. A drain pops the emit command, then reads and presents each beat in turn,
// with any beat_stall holding a beat; rx_stall rises once the command queue fills. Reset
// clears the framing counter, the expectations and the queue at once; the memory needs no
// clearing, as only written bytes are read.
//
module packet_reassembler_core import prc_pkg::*; #(
	parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        beat_valid,
	input  logic        beat_stall,
	output logic [63:0] data_word,
	output logic [3:0]  valid_bytes,
	output logic [8:0]  message_length,
	output logic        last_beat
);

	logic     rx_accept;
	logic     q_push;
	prc_cmd_t q_in;
	logic     q_full;
	logic     q_pop;
	prc_cmd_t q_head;
	logic     q_empty;

	// hold the input off while the queue has no room
	assign rx_stall  = q_full;
	assign rx_accept = rx_valid && !q_full;

	// frame and classify
	prc_front #(
		.PACKET_BYTES  (PACKET_BYTES),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_accept (rx_accept),
		.rx_byte   (rx_byte),
		.cmd_push  (q_push),
		.cmd       (q_in)
	);

	// decouple framing from the drain
	prc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (q_head),
		.empty    (q_empty)
	);

	// store bytes and drain messages
	prc_back #(
		.PACKET_BYTES  (PACKET_BYTES),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (q_empty),
		.cmd            (q_head),
		.cmd_pop        (q_pop),
		.beat_valid     (beat_valid),
		.beat_stall     (beat_stall),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.message_length (message_length),
		.last_beat      (last_beat)
	);

`include "packet_reassembler_core_assert.svh"

	// every beat but the last is full
	`PRC_ASSERT_NOW(a_full_beat, beat_valid && !last_beat, valid_bytes == 4'(BEAT_BYTES), "short beat before the end of a message")
	// the last beat carries the length remainder
	`PRC_ASSERT_NOW(a_tail_len, beat_valid && last_beat, message_length[2:0] == valid_bytes[2:0], "last beat disagrees with message length")
	// a taken last beat returns the drain to idle
	`PRC_ASSERT_NEXT(a_gap_after_last, beat_valid && !beat_stall && last_beat, !beat_valid, "beat shown straight after a last beat")

endmodule
